// ===== rtl/bmp_pkg.sv =====
`timescale 1ns / 1ps

package bmp_pkg;

  typedef enum logic [3:0] {
    OP_WR_PRI     = 4'd0,
    OP_RD_PRI     = 4'd1,
    OP_WR_EXT     = 4'd2,
    OP_RD_EXT     = 4'd3,
    OP_WR_P3      = 4'd4,
    OP_RD_P3      = 4'd5,
    OP_UNLOCK     = 4'd6,
    OP_ALLRAM     = 4'd7,
    OP_REMEMBER   = 4'd8,
    OP_SET_BANK   = 4'd9,
    OP_ALLRAM_OFF = 4'd10
  } op_t;

  typedef enum logic [1:0] {
    KIND_ACK  = 2'd0,
    KIND_PAGE = 2'd1,
    KIND_SLOT = 2'd2
  } kind_t;

  localparam int MaxCmds = 5;

  localparam logic [7:0] ROM_PAGE     = 8'hFF;
  localparam logic [7:0] RESTORE_BANK2 = 8'd5;
  localparam logic [7:0] RESTORE_BANK3 = 8'd2;

  localparam logic [7:0] ALLRAM_ROWS [0:3][0:3] = '{
    '{8'd0, 8'd1, 8'd2, 8'd3},
    '{8'd4, 8'd5, 8'd6, 8'd7},
    '{8'd4, 8'd5, 8'd6, 8'd3},
    '{8'd4, 8'd7, 8'd6, 8'd3}
  };

  typedef struct packed {
    kind_t       kind;
    logic [2:0]  slot;
    logic [7:0]  target;
  } cmd_t;

  typedef struct packed {
    logic        bad_selector;
    logic        lock_state;
    logic        screen_alternate;
    logic [1:0]  rom_choice;
    logic [7:0]  read_data;
  } status_t;

endpackage

// ===== rtl/banked_memory_paging_ports_core.sv =====
`timescale 1ns / 1ps
// Channel  Group  tdata (low bit up)                              tuser       tlast
// input    s_*    data[7:0]                                       op[3:0]     -
// output   m_*    slot, target, read_data, rom_choice,            kind[1:0]   last
//                 screen_alternate, lock_state, bad_selector
// An accepted transaction is decoded into a result buffer of up to five results (mapping
// commands, or one acknowledge), which then leave at one per cycle while m_tready is high.
// The next transaction is taken in the cycle in which the buffer's final result is taken.
// A stall on m_tready holds the current result and holds s_tready low while results remain.
// Reset (rst, synchronous) clears the paging state and empties the buffer.

module banked_memory_paging_ports_core
  import bmp_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [7:0]  s_tdata,   // data[7:0]
  input  logic [3:0]  s_tuser,   // op[3:0]
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [23:0] m_tdata,   // slot[2:0], target[10:3], read_data[18:11],
                                 // rom_choice[20:19], screen_alternate[21],
                                 // lock_state[22], bad_selector[23]
  output logic [1:0]  m_tuser,   // kind[1:0]
  output logic        m_tlast
);

  logic        port_locked, port_locked_next;
  logic [6:0]  top_bank, top_bank_next;
  logic        special_mode, special_mode_next;
  logic [1:0]  rom_sel, rom_sel_next;
  logic        alt_screen, alt_screen_next;

  cmd_t        cmds [MaxCmds];
  cmd_t        cmds_next [MaxCmds];
  logic [2:0]  cnt, cnt_next;
  logic [2:0]  idx;
  status_t     status, status_next;
  logic        out_valid;

  op_t         op;
  logic        accept;
  logic        final_beat;
  logic        do_refresh;
  logic        do_allram;
  logic [1:0]  allram_sel;
  logic [7:0]  rd;
  logic        bad;

  assign op         = op_t'(s_tuser);
  assign final_beat = (idx == cnt - 3'd1);
  assign s_tready   = !out_valid || (m_tready && final_beat);
  assign accept     = s_tvalid && s_tready;

  always_comb begin
    port_locked_next  = port_locked;
    top_bank_next     = top_bank;
    special_mode_next = special_mode;
    rom_sel_next      = rom_sel;
    alt_screen_next   = alt_screen;
    do_refresh        = 1'b0;
    do_allram         = 1'b0;
    allram_sel        = 2'd0;
    rd                = 8'd0;
    bad               = 1'b0;
    for (int i = 0; i < MaxCmds; i++) begin
      cmds_next[i] = '{kind: KIND_ACK, slot: 3'd0, target: 8'd0};
    end
    cnt_next = 3'd1;

    unique case (op)
      OP_WR_PRI: begin
        if (!port_locked) begin
          rom_sel_next    = {rom_sel[1], s_tdata[4]};
          alt_screen_next = s_tdata[3];
          top_bank_next   = {top_bank[6:3], s_tdata[2:0]};
          if (s_tdata[5]) begin
            port_locked_next = 1'b1;
          end
          do_refresh = 1'b1;
        end
      end
      OP_RD_PRI: begin
        rd = {2'b00, port_locked, rom_sel[0], alt_screen, 1'b0, top_bank[1:0]};
      end
      OP_WR_EXT: begin
        top_bank_next = {s_tdata[3:0], top_bank[2:0]};
        do_refresh    = 1'b1;
      end
      OP_RD_EXT: begin
        rd = 8'hFF;
      end
      OP_WR_P3: begin
        if (s_tdata[0]) begin
          do_allram         = 1'b1;
          allram_sel        = s_tdata[2:1];
          special_mode_next = 1'b1;
        end else begin
          rom_sel_next = {s_tdata[2], rom_sel[0]};
          do_refresh   = 1'b1;
        end
      end
      OP_RD_P3: begin
        rd = {5'd0, rom_sel[1], 2'b00};
      end
      OP_UNLOCK: begin
        port_locked_next = 1'b0;
      end
      OP_ALLRAM: begin
        if (s_tdata[7:2] != 6'd0) begin
          bad = 1'b1;
        end else begin
          do_allram  = 1'b1;
          allram_sel = s_tdata[1:0];
        end
      end
      OP_REMEMBER: begin
        top_bank_next = s_tdata[6:0];
      end
      OP_SET_BANK: begin
        top_bank_next = s_tdata[6:0];
        cmds_next[0]  = '{kind: KIND_SLOT, slot: 3'd4, target: {1'b0, s_tdata[6:0]}};
      end
      OP_ALLRAM_OFF: begin
        do_refresh = special_mode;
      end
      default: begin
      end
    endcase

    if (do_refresh) begin
      cmds_next[0]      = '{kind: KIND_PAGE, slot: 3'd0, target: ROM_PAGE};
      cmds_next[1]      = '{kind: KIND_PAGE, slot: 3'd1, target: ROM_PAGE};
      cmds_next[2]      = '{kind: KIND_SLOT, slot: 3'd4, target: {1'b0, top_bank_next}};
      cmds_next[3]      = '{kind: KIND_SLOT, slot: 3'd2, target: RESTORE_BANK2};
      cmds_next[4]      = '{kind: KIND_SLOT, slot: 3'd3, target: RESTORE_BANK3};
      cnt_next          = special_mode ? 3'd5 : 3'd3;
      special_mode_next = 1'b0;
    end

    if (do_allram) begin
      for (int i = 0; i < 4; i++) begin
        cmds_next[i] = '{kind: KIND_SLOT, slot: 3'(i + 1),
                         target: ALLRAM_ROWS[allram_sel][i]};
      end
      cnt_next = 3'd4;
    end

    status_next = '{bad_selector: bad, lock_state: port_locked_next,
                    screen_alternate: alt_screen_next, rom_choice: rom_sel_next,
                    read_data: rd};
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      port_locked  <= 1'b0;
      top_bank     <= 7'd0;
      special_mode <= 1'b0;
      rom_sel      <= 2'd0;
      alt_screen   <= 1'b0;
      out_valid    <= 1'b0;
      idx          <= 3'd0;
      cnt          <= 3'd1;
    end else if (accept) begin
      port_locked  <= port_locked_next;
      top_bank     <= top_bank_next;
      special_mode <= special_mode_next;
      rom_sel      <= rom_sel_next;
      alt_screen   <= alt_screen_next;
      out_valid    <= 1'b1;
      idx          <= 3'd0;
      cnt          <= cnt_next;
    end else if (out_valid && m_tready) begin
      if (final_beat) begin
        out_valid <= 1'b0;
      end else begin
        idx <= idx + 3'd1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      cmds   <= cmds_next;
      status <= status_next;
    end
  end

  assign m_tvalid = out_valid;
  assign m_tuser  = cmds[idx].kind;
  assign m_tdata  = {status, cmds[idx].target, cmds[idx].slot};
  assign m_tlast  = final_beat;

`ifndef SYNTHESIS
  a_idx_in_range: assert property (@(posedge clk) disable iff (rst)
    m_tvalid |-> (idx < cnt))
    else $error("result index beyond buffered command count");

  a_ready_only_when_drained: assert property (@(posedge clk) disable iff (rst)
    s_tready |-> (!m_tvalid || (m_tready && m_tlast)))
    else $error("input taken while buffered results remain");

  a_ack_is_single: assert property (@(posedge clk) disable iff (rst)
    (m_tvalid && m_tuser == KIND_ACK) |-> (m_tlast && idx == 3'd0))
    else $error("acknowledge is not a single-result transaction");

  a_bad_only_on_ack: assert property (@(posedge clk) disable iff (rst)
    (m_tvalid && m_tdata[23]) |-> (m_tuser == KIND_ACK))
    else $error("bad selector flagged on a mapping command");
`endif

endmodule
